>>> hdl/lpht_pkg.sv
// Shared types, sizes and status codes for the linear-probe hash table.
package lpht_pkg;

    // Table geometry; the slot count is a power of two so the home slot is the key's low bits
    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int LOAD_LIMIT    = TABLE_ENTRIES / 2 + TABLE_ENTRIES / 4;
    localparam int KEY_W         = 64;
    localparam int VAL_W         = 64;

    // Job queue between front and back
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W       = $clog2(QUEUE_DEPTH + 1);

    // Operation codes
    localparam logic OP_FIND   = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_EXISTED  = 3'd1;
    localparam logic [2:0] ST_FOUND    = 3'd2;
    localparam logic [2:0] ST_MISSING  = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic             operation;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic [2:0]       status;
        logic [VAL_W-1:0] value_out;
    } t_result;

    // Classified job as it travels through the queue
    typedef struct packed {
        logic             operation;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] home;
    } t_job;

endpackage

>>> hdl/linear_probe_hash_table.sv
// From an accepted start the item is queued, popped in idle, then its home slot is read and checked;
// each extra probe repeats the RAM read and check. A refused insert (table at load limit) is answered from idle.
// The probe engine takes a new job only once it is back in idle; a 2-entry queue absorbs bursts.
// Reset (i_rst_n low, synchronous) starts a sweep that zeroes all 1024 key-store slots; busy is high.
// Results are strobed on o_done for one cycle and cannot be held off by the receiver.
module linear_probe_hash_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  lpht_pkg::t_item   i_item,
    output logic              busy,
    output logic              o_done,
    output lpht_pkg::t_result o_result
);
    import lpht_pkg::*;

    logic queue_full;
    logic queue_valid;
    logic push;
    logic pop;
    logic clearing;
    t_job job_in;
    t_job job_head;

    lpht_front u_front (
        .i_start      (start),
        .i_item       (i_item),
        .i_queue_full (queue_full),
        .i_clearing   (clearing),
        .o_busy       (busy),
        .o_push       (push),
        .o_job        (job_in)
    );

    lpht_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_head  (job_head)
    );

    lpht_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (queue_valid),
        .i_job      (job_head),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_done     (o_done),
        .o_result   (o_result)
    );

endmodule

>>> hdl/lpht_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lpht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/lpht_front.sv
// Command front end: accepts items, normalizes the key and computes the home slot.
module lpht_front (
    input  logic          i_start,
    input  lpht_pkg::t_item i_item,
    input  logic          i_queue_full,
    input  logic          i_clearing,
    output logic          o_busy,
    output logic          o_push,
    output lpht_pkg::t_job o_job
);
    import lpht_pkg::*;

    logic [KEY_W-1:0] key_norm;

    // Refuse commands while the queue is full or the key store is being cleared
    assign o_busy = i_queue_full | i_clearing;
    assign o_push = i_start & ~o_busy;

    // Key zero marks an empty slot, so take it as key one
    assign key_norm = (i_item.key == '0) ? KEY_W'(1) : i_item.key;

    // Build the job
    always_comb begin
        o_job.operation = i_item.operation;
        o_job.key       = key_norm;
        o_job.value     = i_item.value;
        o_job.home      = key_norm[IDX_W-1:0];
    end

endmodule

>>> hdl/lpht_queue.sv
// Short job queue that decouples the command front end from the probe engine.
module lpht_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lpht_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output lpht_pkg::t_job o_head
);
    import lpht_pkg::*;

    t_job               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QFILL_W-1:0] r_fill;

    assign o_full  = (r_fill == QFILL_W'(QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_head  = r_mem[r_rd];

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

>>> hdl/lpht_back.sv
// Probe engine: clears the key store after reset, then walks probe paths job by job.
module lpht_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  lpht_pkg::t_job    i_job,
    output logic              o_pop,
    output logic              o_clearing,
    output logic              o_done,
    output lpht_pkg::t_result o_result
);
    import lpht_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;
    localparam logic [1:0] S_CHECK = 2'd3;

    logic [1:0]       r_state,   n_state;
    logic [IDX_W-1:0] r_pos,     n_pos;
    logic [IDX_W-1:0] r_probes,  n_probes;
    logic [CNT_W-1:0] r_count,   n_count;
    logic             r_op,      n_op;
    logic [KEY_W-1:0] r_key,     n_key;
    logic [VAL_W-1:0] r_value,   n_value;
    logic             r_done,    n_done;
    t_result          r_result,  n_result;

    logic             key_we;
    logic [KEY_W-1:0] key_wdata;
    logic             val_we;
    logic             rd_en;
    logic [KEY_W-1:0] key_rdata;
    logic [VAL_W-1:0] val_rdata;
    logic             hit_key;
    logic             hit_empty;
    logic [IDX_W-1:0] pos_next;

    lpht_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_pos),
        .i_wdata (key_wdata),
        .i_re    (rd_en),
        .i_raddr (r_pos),
        .o_rdata (key_rdata)
    );

    lpht_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_ENTRIES)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (r_pos),
        .i_wdata (r_value),
        .i_re    (rd_en),
        .i_raddr (r_pos),
        .o_rdata (val_rdata)
    );

    assign o_clearing = (r_state == S_CLEAR);
    assign o_pop      = (r_state == S_IDLE) & i_valid;
    assign o_done     = r_done;
    assign o_result   = r_result;
    assign rd_en      = (r_state == S_PROBE);
    assign hit_key    = (key_rdata == r_key);
    assign hit_empty  = (key_rdata == '0);
    assign pos_next   = (r_pos == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : r_pos + 1'b1;

    // Key store writes: zeros during the clearing sweep, the new key on an insert
    always_comb begin
        key_we    = 1'b0;
        key_wdata = r_key;
        val_we    = 1'b0;
        if (r_state == S_CLEAR) begin
            key_we    = 1'b1;
            key_wdata = '0;
        end else if (r_state == S_CHECK && !hit_key && hit_empty && r_op == OP_INSERT) begin
            key_we = 1'b1;
            val_we = 1'b1;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_probes = r_probes;
        n_count  = r_count;
        n_op     = r_op;
        n_key    = r_key;
        n_value  = r_value;
        n_done   = 1'b0;
        n_result = r_result;
        unique case (r_state)
            S_CLEAR: begin
                n_pos = pos_next;
                if (r_pos == IDX_W'(TABLE_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_op     = i_job.operation;
                    n_key    = i_job.key;
                    n_value  = i_job.value;
                    n_pos    = i_job.home;
                    n_probes = '0;
                    if (i_job.operation == OP_INSERT && r_count >= CNT_W'(LOAD_LIMIT)) begin
                        n_done   = 1'b1;
                        n_result = '{status: ST_FULL, value_out: '0};
                    end else begin
                        n_state = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                priority if (hit_key) begin
                    n_done   = 1'b1;
                    n_result = '{status: (r_op == OP_INSERT) ? ST_EXISTED : ST_FOUND,
                                 value_out: val_rdata};
                    n_state  = S_IDLE;
                end else if (hit_empty) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    if (r_op == OP_INSERT) begin
                        n_count  = r_count + 1'b1;
                        n_result = '{status: ST_INSERTED, value_out: '0};
                    end else begin
                        n_result = '{status: ST_MISSING, value_out: '0};
                    end
                end else if (r_probes == IDX_W'(TABLE_ENTRIES - 1)) begin
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                    n_result = '{status: (r_op == OP_INSERT) ? ST_FULL : ST_MISSING,
                                 value_out: '0};
                end else begin
                    n_pos    = pos_next;
                    n_probes = r_probes + 1'b1;
                    n_state  = S_PROBE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_pos   <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // Job and result payload
    always_ff @(posedge i_clk) begin
        r_probes <= n_probes;
        r_op     <= n_op;
        r_key    <= n_key;
        r_value  <= n_value;
        r_result <= n_result;
    end

    // The occupancy never passes the load limit
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(LOAD_LIMIT))
        else $error("entry count above load limit");

    // A result comes only from a check or from a refused insert in idle
    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_state) == S_CHECK || $past(r_state) == S_IDLE))
        else $error("result strobe from wrong state");

    // An insert write always bumps the occupancy
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        val_we |=> r_count == $past(r_count) + 1'b1)
        else $error("insert without count update");

    // No job is taken during the clearing sweep
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_clearing |-> !o_pop)
        else $error("job popped while clearing");

endmodule

>>> tb/sv/linear_probe_hash_table_tb.sv
// Self-checking testbench for the linear-probe hash table: finds, inserts, collisions and load limit.
module linear_probe_hash_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpht_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS  = 10;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_item   i_item;
    logic    busy;
    logic    o_done;
    t_result o_result;

    // Shadow copy of the table contents
    logic [KEY_W-1:0] shadow_keys   [TABLE_ENTRIES];
    logic [VAL_W-1:0] shadow_values [TABLE_ENTRIES];
    int unsigned      shadow_count;

    t_result          pending_results[$];
    logic [KEY_W-1:0] stored_keys[$];
    int               sender_idle_pct;
    int               mismatch_count = 0;
    int               result_index   = 0;
    int               cycle_count    = 0;

    linear_probe_hash_table dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Walk the probe path, then apply the find or insert to the shadow table
    function automatic t_result predict_table_op(input t_item item);
        logic [KEY_W-1:0] k;
        int               pos;
        int               n;
        bit               located;
        t_result          res;
        k       = (item.key == '0) ? KEY_W'(1) : item.key;
        pos     = int'(k % TABLE_ENTRIES);
        located = 1'b0;
        for (n = 0; n < TABLE_ENTRIES && !located; n++) begin
            if (shadow_keys[pos] == '0 || shadow_keys[pos] == k) begin
                located = 1'b1;
            end else begin
                pos = (pos + 1) % TABLE_ENTRIES;
            end
        end
        res.value_out = '0;
        if (item.operation == OP_FIND) begin
            if (located && shadow_keys[pos] == k) begin
                res.status    = ST_FOUND;
                res.value_out = shadow_values[pos];
            end else begin
                res.status = ST_MISSING;
            end
        end else if (shadow_count >= LOAD_LIMIT || !located) begin
            res.status = ST_FULL;
        end else if (shadow_keys[pos] == k) begin
            res.status    = ST_EXISTED;
            res.value_out = shadow_values[pos];
        end else begin
            shadow_keys[pos]   = k;
            shadow_values[pos] = item.value;
            shadow_count++;
            stored_keys.push_back(k);
            res.status = ST_INSERTED;
        end
        return res;
    endfunction

    function automatic logic [63:0] random_word();
        return {$urandom(), $urandom()};
    endfunction

    // Choose a key: a stored one, one homed near the wrap point, a corner value, or random
    function automatic logic [KEY_W-1:0] pick_key(input int hit_pct);
        int               roll;
        logic [KEY_W-1:0] w;
        roll = $urandom_range(99);
        w    = random_word();
        if (roll < hit_pct && stored_keys.size() > 0) begin
            w = stored_keys[$urandom_range(stored_keys.size() - 1)];
        end else if (roll < hit_pct + 12) begin
            w[IDX_W-1:0] = IDX_W'(TABLE_ENTRIES - 8 + $urandom_range(15));
        end else if (roll < hit_pct + 16) begin
            case ($urandom_range(2))
                0:       w = '0;
                1:       w = KEY_W'(1);
                default: w = '1;
            endcase
        end
        return w;
    endfunction

    // Hold start until the block takes the transfer, then log the expected result
    task automatic send_item(input logic op, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] value);
        t_item item;
        item.operation = op;
        item.key       = key;
        item.value     = value;
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= item;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        pending_results.push_back(predict_table_op(item));
    endtask

    task automatic test_directed_cases();
        sender_idle_pct = 33;
        // Empty table: misses, including key zero
        send_item(OP_FIND,   64'd5, '0);
        send_item(OP_FIND,   '0,    '0);
        // Key zero is stored as one
        send_item(OP_INSERT, '0,    '1);
        send_item(OP_FIND,   64'd1, '0);
        send_item(OP_FIND,   '0,    random_word());
        send_item(OP_INSERT, 64'd1, '0);
        // Last slot, then a collision that wraps to slot zero
        send_item(OP_INSERT, '1,    '0);
        send_item(OP_INSERT, 64'h7FF, 64'h5555_5555_5555_5555);
        // Slots zero and one both taken: probe to slot two
        send_item(OP_INSERT, 64'h8000_0000_0000_0000, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(OP_FIND,   64'h7FF, '1);
        send_item(OP_FIND,   64'h8000_0000_0000_0000, '0);
        // Miss that walks across the wrap
        send_item(OP_FIND,   64'hBFF, '0);
        send_item(OP_FIND,   64'h802, '0);
        // Existing keys keep their old value
        send_item(OP_INSERT, '1,    '1);
        send_item(OP_INSERT, 64'h8000_0000_0000_0000, '1);
        send_item(OP_FIND,   '1,    random_word());
        send_item(OP_INSERT, random_word(), '1);
        send_item(OP_INSERT, random_word(), '0);
    endtask

    task automatic test_random_mix();
        sender_idle_pct = 33;
        repeat (400) begin
            send_item($urandom_range(1) ? OP_INSERT : OP_FIND, pick_key(40), random_word());
        end
    endtask

    task automatic test_fill_to_limit();
        sender_idle_pct = 53;
        while (shadow_count < LOAD_LIMIT) begin
            send_item(($urandom_range(99) < 95) ? OP_INSERT : OP_FIND, pick_key(10),
                      random_word());
        end
    endtask

    task automatic test_full_table();
        sender_idle_pct = 0;
        // Refused even for keys already stored
        send_item(OP_INSERT, stored_keys[0], random_word());
        send_item(OP_INSERT, '0, '1);
        repeat (380) begin
            send_item($urandom_range(1) ? OP_INSERT : OP_FIND, pick_key(50), random_word());
        end
    endtask

    // Compare each strobed result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                if (mismatch_count < MAX_REPORTS) begin
                    $display("result %0d unexpected: status %0d value %h",
                             result_index, o_result.status, o_result.value_out);
                end
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.status !== want.status || o_result.value_out !== want.value_out) begin
                    if (mismatch_count < MAX_REPORTS) begin
                        $display("result %0d mismatch: status exp %0d got %0d, value exp %h got %h",
                                 result_index, want.status, o_result.status,
                                 want.value_out, o_result.value_out);
                    end
                    mismatch_count++;
                end
            end
            result_index++;
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_item         = '0;
        shadow_count   = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            shadow_keys[i]   = '0;
            shadow_values[i] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_mix();
        test_fill_to_limit();
        test_full_table();
        start <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
